// File: hdl/bmrb_pkg.sv
// ----------------------------------------------------------------------------
// Box mesh rotate bounds package
// Shared widths, codes, the corner table and fixed-point helpers.
// ----------------------------------------------------------------------------
package bmrb_pkg;

   localparam int COORD_W          = 16;
   localparam int HALF_W           = 15;
   localparam int TRIG_W           = 16;
   localparam int NUM_W            = 10;
   localparam int OFS_W            = 17;
   localparam int DELTA_W          = 18;
   localparam int PROD_W           = 34;
   localparam int ACC_W            = 35;
   localparam int FRAC_SHIFT       = 14;
   localparam int ROT_W            = ACC_W - FRAC_SHIFT;
   localparam int WIDE_W           = 22;
   localparam int NUM_CORNERS      = 24;
   localparam int STEP_W           = $clog2(NUM_CORNERS);
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int DEF_MAX_VERTICES = 1024;

   localparam logic OP_BOX    = 1'b0;
   localparam logic OP_BOUNDS = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic        [HALF_W-1:0]  half_type;
   typedef logic signed [TRIG_W-1:0]  trig_type;

   typedef enum logic [1:0] {
      KIND_VERTEX = 2'd0,
      KIND_MIN    = 2'd1,
      KIND_MAX    = 2'd2
   } kind_type;

   typedef struct packed {
      logic      is_bounds;
      coord_type center_x;
      coord_type center_y;
      coord_type center_z;
      half_type  half_x;
      half_type  half_y;
      half_type  half_z;
      coord_type pivot_y;
      coord_type pivot_z;
      trig_type  cos_angle;
      trig_type  sin_angle;
      logic      rotate;
   } item_type;

   // Bits are x positive, y positive, z positive, u, v.
   typedef struct packed {
      logic x_pos;
      logic y_pos;
      logic z_pos;
      logic tex_u;
      logic tex_v;
   } corner_type;

   localparam corner_type CORNER_TAB [NUM_CORNERS] = '{
      5'b10000, 5'b11001, 5'b11111, 5'b10110,
      5'b00110, 5'b01111, 5'b01001, 5'b00000,
      5'b01101, 5'b11111, 5'b11010, 5'b01000,
      5'b00000, 5'b10010, 5'b10111, 5'b00101,
      5'b00100, 5'b10110, 5'b11111, 5'b01101,
      5'b10010, 5'b00000, 5'b01001, 5'b11011
   };

   function automatic logic signed [OFS_W-1:0] corner_offset(
      input coord_type center,
      input half_type  half,
      input logic      pos
   );
      logic signed [OFS_W-1:0] c;
      logic signed [OFS_W-1:0] h;
      c = OFS_W'(center);
      h = signed'({{(OFS_W-HALF_W){1'b0}}, half});
      return pos ? c + h : c - h;
   endfunction

   function automatic coord_type sat_coord(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(signed'(16'sh7fff));
      lo = WIDE_W'(signed'(16'sh8000));
      if (v > hi) begin
         return 16'sh7fff;
      end else if (v < lo) begin
         return 16'sh8000;
      end
      return v[COORD_W-1:0];
   endfunction

endpackage

// File: hdl/bmrb_channels.sv
// ----------------------------------------------------------------------------
// Box mesh rotate bounds channels
// Valid/ready interfaces for the box request and the vertex response.
// ----------------------------------------------------------------------------
interface bmrb_req_if;
   logic                valid;
   logic                ready;
   logic                op;
   bmrb_pkg::coord_type center_x;
   bmrb_pkg::coord_type center_y;
   bmrb_pkg::coord_type center_z;
   bmrb_pkg::half_type  half_x;
   bmrb_pkg::half_type  half_y;
   bmrb_pkg::half_type  half_z;
   bmrb_pkg::coord_type pivot_y;
   bmrb_pkg::coord_type pivot_z;
   bmrb_pkg::trig_type  cos_angle;
   bmrb_pkg::trig_type  sin_angle;
   logic                rotate;

   modport source (
      output valid, op, center_x, center_y, center_z, half_x, half_y, half_z,
             pivot_y, pivot_z, cos_angle, sin_angle, rotate,
      input  ready
   );
   modport sink (
      input  valid, op, center_x, center_y, center_z, half_x, half_y, half_z,
             pivot_y, pivot_z, cos_angle, sin_angle, rotate,
      output ready
   );
endinterface

interface bmrb_rsp_if;
   logic                        valid;
   logic                        ready;
   bmrb_pkg::kind_type          kind;
   bmrb_pkg::coord_type         pos_x;
   bmrb_pkg::coord_type         pos_y;
   bmrb_pkg::coord_type         pos_z;
   logic                        tex_u;
   logic                        tex_v;
   logic [bmrb_pkg::NUM_W-1:0]  vertex_number;
   logic                        last;

   modport source (
      output valid, kind, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_number, last,
      input  ready
   );
   modport sink (
      input  valid, kind, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_number, last,
      output ready
   );
endinterface

// File: hdl/bmrb_front.sv
// ----------------------------------------------------------------------------
// Box mesh rotate bounds front end
// Accepts request transfers, decodes the operation and queues the items.
// ----------------------------------------------------------------------------
module bmrb_front (
   input  logic               clock,
   input  logic               reset,
   bmrb_req_if.sink           req_chan,
   output bmrb_pkg::item_type head,
   output logic               head_valid,
   input  logic               head_pop
);

   bmrb_pkg::item_type                   queue_ff [bmrb_pkg::QUEUE_DEPTH];
   logic [bmrb_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [bmrb_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [bmrb_pkg::QUEUE_CNT_W-1:0]     fill_ff, fill_in;
   bmrb_pkg::item_type                   item;
   logic                                 push;
   logic                                 pop;

   localparam logic [bmrb_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
      bmrb_pkg::QUEUE_PTR_W'(bmrb_pkg::QUEUE_DEPTH - 1);
   localparam logic [bmrb_pkg::QUEUE_CNT_W-1:0] FILL_FULL =
      bmrb_pkg::QUEUE_CNT_W'(bmrb_pkg::QUEUE_DEPTH);

   assign req_chan.ready = (fill_ff != FILL_FULL);
   assign push           = req_chan.valid && req_chan.ready;
   assign pop            = head_pop && head_valid;
   assign head_valid     = (fill_ff != '0);
   assign head           = queue_ff[rd_ptr_ff];

   always_comb begin
      item.is_bounds = (req_chan.op == bmrb_pkg::OP_BOUNDS);
      item.center_x  = req_chan.center_x;
      item.center_y  = req_chan.center_y;
      item.center_z  = req_chan.center_z;
      item.half_x    = req_chan.half_x;
      item.half_y    = req_chan.half_y;
      item.half_z    = req_chan.half_z;
      item.pivot_y   = req_chan.pivot_y;
      item.pivot_z   = req_chan.pivot_z;
      item.cos_angle = req_chan.cos_angle;
      item.sin_angle = req_chan.sin_angle;
      item.rotate    = req_chan.rotate;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// File: hdl/bmrb_back.sv
// ----------------------------------------------------------------------------
// Box mesh rotate bounds back end
// Walks the corners of the head item through a rotate pipeline, tracks the
// bounds and vertex count, and holds the response register.
// ----------------------------------------------------------------------------
module bmrb_back #(
   parameter int MAX_VERTICES = bmrb_pkg::DEF_MAX_VERTICES
) (
   input  logic               clock,
   input  logic               reset,
   input  bmrb_pkg::item_type head,
   input  logic               head_valid,
   output logic               head_pop,
   bmrb_rsp_if.source         rsp_chan
);

   localparam int CNT_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_VERTICES - 1);
   localparam logic [bmrb_pkg::STEP_W-1:0] STEP_LAST =
      bmrb_pkg::STEP_W'(bmrb_pkg::NUM_CORNERS - 1);
   localparam logic [bmrb_pkg::STEP_W-1:0] STEP_ONE = bmrb_pkg::STEP_W'(1);

   typedef struct packed {
      logic                                    valid;
      bmrb_pkg::kind_type                      kind;
      bmrb_pkg::coord_type                     pos_x;
      logic signed [bmrb_pkg::OFS_W-1:0]       ly;
      logic signed [bmrb_pkg::OFS_W-1:0]       lz;
      logic signed [bmrb_pkg::DELTA_W-1:0]     dy;
      logic signed [bmrb_pkg::DELTA_W-1:0]     dz;
      bmrb_pkg::coord_type                     pivot_y;
      bmrb_pkg::coord_type                     pivot_z;
      bmrb_pkg::trig_type                      cos_angle;
      bmrb_pkg::trig_type                      sin_angle;
      logic                                    rotate;
      logic                                    tex_u;
      logic                                    tex_v;
      logic                                    last;
   } s1_type;

   typedef struct packed {
      logic                                    valid;
      bmrb_pkg::kind_type                      kind;
      bmrb_pkg::coord_type                     pos_x;
      logic signed [bmrb_pkg::OFS_W-1:0]       ly;
      logic signed [bmrb_pkg::OFS_W-1:0]       lz;
      bmrb_pkg::coord_type                     pivot_y;
      bmrb_pkg::coord_type                     pivot_z;
      logic signed [bmrb_pkg::PROD_W-1:0]      m_yc;
      logic signed [bmrb_pkg::PROD_W-1:0]      m_zs;
      logic signed [bmrb_pkg::PROD_W-1:0]      m_ys;
      logic signed [bmrb_pkg::PROD_W-1:0]      m_zc;
      logic                                    rotate;
      logic                                    tex_u;
      logic                                    tex_v;
      logic                                    last;
   } s2_type;

   typedef struct packed {
      logic                valid;
      bmrb_pkg::kind_type  kind;
      bmrb_pkg::coord_type pos_x;
      bmrb_pkg::coord_type pos_y;
      bmrb_pkg::coord_type pos_z;
      logic                tex_u;
      logic                tex_v;
      logic                last;
   } s3_type;

   typedef struct packed {
      bmrb_pkg::kind_type            kind;
      bmrb_pkg::coord_type           pos_x;
      bmrb_pkg::coord_type           pos_y;
      bmrb_pkg::coord_type           pos_z;
      logic                          tex_u;
      logic                          tex_v;
      logic [bmrb_pkg::NUM_W-1:0]    vertex_number;
      logic                          last;
   } out_type;

   logic                              advance;
   logic                              last_step;
   logic [bmrb_pkg::STEP_W-1:0]       step_ff, step_in;
   bmrb_pkg::corner_type              corner;
   logic signed [bmrb_pkg::OFS_W-1:0] x_sum, y_sum, z_sum;
   logic signed [bmrb_pkg::DELTA_W-1:0] y_ext, z_ext, py_ext, pz_ext;
   logic signed [bmrb_pkg::WIDE_W-1:0]  x_wide;
   s1_type                            s1_ff, s1_in;
   s2_type                            s2_ff, s2_in;
   s3_type                            s3_ff, s3_in;
   logic signed [bmrb_pkg::ACC_W-1:0] acc_y, acc_z;
   logic signed [bmrb_pkg::ROT_W-1:0] rot_y, rot_z;
   logic signed [bmrb_pkg::WIDE_W-1:0]  rot_y_wide, rot_z_wide, ly_wide, lz_wide;
   bmrb_pkg::coord_type               min_ff [3];
   bmrb_pkg::coord_type               min_in [3];
   bmrb_pkg::coord_type               max_ff [3];
   bmrb_pkg::coord_type               max_in [3];
   bmrb_pkg::coord_type               point [3];
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [CNT_W+bmrb_pkg::NUM_W-1:0]  count_ext;
   logic                              rsp_valid_ff, rsp_valid_in;
   out_type                           out_ff, out_in;

   assign advance   = !rsp_valid_ff || rsp_chan.ready;
   assign last_step = head.is_bounds ? (step_ff == STEP_ONE) : (step_ff == STEP_LAST);
   assign head_pop  = head_valid && advance && last_step;

   always_comb begin
      step_in = step_ff;
      if (head_valid && advance) begin
         step_in = last_step ? '0 : step_ff + 1'b1;
      end
   end

   always_comb begin
      corner = bmrb_pkg::CORNER_TAB[step_ff];
      x_sum  = bmrb_pkg::corner_offset(head.center_x, head.half_x, corner.x_pos);
      y_sum  = bmrb_pkg::corner_offset(head.center_y, head.half_y, corner.y_pos);
      z_sum  = bmrb_pkg::corner_offset(head.center_z, head.half_z, corner.z_pos);
      y_ext  = bmrb_pkg::DELTA_W'(y_sum);
      z_ext  = bmrb_pkg::DELTA_W'(z_sum);
      py_ext = bmrb_pkg::DELTA_W'(head.pivot_y);
      pz_ext = bmrb_pkg::DELTA_W'(head.pivot_z);
      x_wide = bmrb_pkg::WIDE_W'(x_sum);

      s1_in.valid     = head_valid;
      if (!head.is_bounds) begin
         s1_in.kind = bmrb_pkg::KIND_VERTEX;
      end else if (step_ff == '0) begin
         s1_in.kind = bmrb_pkg::KIND_MIN;
      end else begin
         s1_in.kind = bmrb_pkg::KIND_MAX;
      end
      s1_in.pos_x     = bmrb_pkg::sat_coord(x_wide);
      s1_in.ly        = y_sum;
      s1_in.lz        = z_sum;
      s1_in.dy        = y_ext - py_ext;
      s1_in.dz        = z_ext - pz_ext;
      s1_in.pivot_y   = head.pivot_y;
      s1_in.pivot_z   = head.pivot_z;
      s1_in.cos_angle = head.cos_angle;
      s1_in.sin_angle = head.sin_angle;
      s1_in.rotate    = head.rotate;
      s1_in.tex_u     = corner.tex_u;
      s1_in.tex_v     = corner.tex_v;
      s1_in.last      = last_step;
   end

   always_comb begin
      s2_in.valid   = s1_ff.valid;
      s2_in.kind    = s1_ff.kind;
      s2_in.pos_x   = s1_ff.pos_x;
      s2_in.ly      = s1_ff.ly;
      s2_in.lz      = s1_ff.lz;
      s2_in.pivot_y = s1_ff.pivot_y;
      s2_in.pivot_z = s1_ff.pivot_z;
      s2_in.m_yc    = s1_ff.dy * s1_ff.cos_angle;
      s2_in.m_zs    = s1_ff.dz * s1_ff.sin_angle;
      s2_in.m_ys    = s1_ff.dy * s1_ff.sin_angle;
      s2_in.m_zc    = s1_ff.dz * s1_ff.cos_angle;
      s2_in.rotate  = s1_ff.rotate;
      s2_in.tex_u   = s1_ff.tex_u;
      s2_in.tex_v   = s1_ff.tex_v;
      s2_in.last    = s1_ff.last;
   end

   always_comb begin
      acc_y      = bmrb_pkg::ACC_W'(s2_ff.m_yc) - bmrb_pkg::ACC_W'(s2_ff.m_zs);
      acc_z      = bmrb_pkg::ACC_W'(s2_ff.m_ys) + bmrb_pkg::ACC_W'(s2_ff.m_zc);
      rot_y      = acc_y[bmrb_pkg::ACC_W-1:bmrb_pkg::FRAC_SHIFT];
      rot_z      = acc_z[bmrb_pkg::ACC_W-1:bmrb_pkg::FRAC_SHIFT];
      rot_y_wide = bmrb_pkg::WIDE_W'(rot_y) + bmrb_pkg::WIDE_W'(s2_ff.pivot_y);
      rot_z_wide = bmrb_pkg::WIDE_W'(rot_z) + bmrb_pkg::WIDE_W'(s2_ff.pivot_z);
      ly_wide    = bmrb_pkg::WIDE_W'(s2_ff.ly);
      lz_wide    = bmrb_pkg::WIDE_W'(s2_ff.lz);

      s3_in.valid = s2_ff.valid;
      s3_in.kind  = s2_ff.kind;
      s3_in.pos_x = s2_ff.pos_x;
      s3_in.pos_y = bmrb_pkg::sat_coord(s2_ff.rotate ? rot_y_wide : ly_wide);
      s3_in.pos_z = bmrb_pkg::sat_coord(s2_ff.rotate ? rot_z_wide : lz_wide);
      s3_in.tex_u = s2_ff.tex_u;
      s3_in.tex_v = s2_ff.tex_v;
      s3_in.last  = s2_ff.last;
   end

   always_comb begin
      point[0]     = s3_ff.pos_x;
      point[1]     = s3_ff.pos_y;
      point[2]     = s3_ff.pos_z;
      count_ext    = (CNT_W + bmrb_pkg::NUM_W)'(count_ff);
      min_in       = min_ff;
      max_in       = max_ff;
      count_in     = count_ff;
      out_in       = out_ff;
      rsp_valid_in = advance ? s3_ff.valid : rsp_valid_ff;
      if (advance && s3_ff.valid) begin
         out_in.kind          = s3_ff.kind;
         out_in.tex_u         = 1'b0;
         out_in.tex_v         = 1'b0;
         out_in.vertex_number = '0;
         out_in.last          = s3_ff.last;
         unique case (s3_ff.kind)
            bmrb_pkg::KIND_VERTEX: begin
               out_in.pos_x         = point[0];
               out_in.pos_y         = point[1];
               out_in.pos_z         = point[2];
               out_in.tex_u         = s3_ff.tex_u;
               out_in.tex_v         = s3_ff.tex_v;
               out_in.vertex_number = count_ext[bmrb_pkg::NUM_W-1:0];
               for (int i = 0; i < 3; i++) begin
                  if (point[i] < min_ff[i]) begin
                     min_in[i] = point[i];
                  end
                  if (point[i] > max_ff[i]) begin
                     max_in[i] = point[i];
                  end
               end
               count_in = (count_ff == CNT_LAST) ? '0 : count_ff + 1'b1;
            end
            bmrb_pkg::KIND_MIN: begin
               out_in.pos_x = min_ff[0];
               out_in.pos_y = min_ff[1];
               out_in.pos_z = min_ff[2];
            end
            bmrb_pkg::KIND_MAX: begin
               out_in.pos_x = max_ff[0];
               out_in.pos_y = max_ff[1];
               out_in.pos_z = max_ff[2];
               for (int i = 0; i < 3; i++) begin
                  min_in[i] = 16'sh7fff;
                  max_in[i] = 16'sh8000;
               end
               count_in = '0;
            end
            default: begin
               out_in.pos_x = point[0];
               out_in.pos_y = point[1];
               out_in.pos_z = point[2];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         s1_ff.valid  <= 1'b0;
         s2_ff.valid  <= 1'b0;
         s3_ff.valid  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         for (int i = 0; i < 3; i++) begin
            min_ff[i] <= 16'sh7fff;
            max_ff[i] <= 16'sh8000;
         end
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         if (advance) begin
            s1_ff <= s1_in;
            s2_ff <= s2_in;
            s3_ff <= s3_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = out_ff.kind;
   assign rsp_chan.pos_x         = out_ff.pos_x;
   assign rsp_chan.pos_y         = out_ff.pos_y;
   assign rsp_chan.pos_z         = out_ff.pos_z;
   assign rsp_chan.tex_u         = out_ff.tex_u;
   assign rsp_chan.tex_v         = out_ff.tex_v;
   assign rsp_chan.vertex_number = out_ff.vertex_number;
   assign rsp_chan.last          = out_ff.last;

endmodule

// File: hdl/box_mesh_rotate_bounds.sv
// ----------------------------------------------------------------------------
// Box mesh rotate bounds
// Tessellates boxes into 24 textured vertices, optionally rotated about the
// X axis, and keeps a running bounding box of the vertices emitted since the last bounds request.
// ----------------------------------------------------------------------------
// The block delivers one response transfer per clock while the response side
// is ready: a box request yields 24 vertex transfers, a bounds request yields
// a minimum and a maximum transfer, and the next request follows with no gap.
// The rate is set by the corner sequencer in the back end, which issues one
// corner per cycle while the response side is ready into a four-stage rotate
// and bounds pipeline (s1, s2, s3 and the response register) fed from the head
// of the two-entry request queue. The queue keeps taking requests while the
// back end works, until both entries are full, and the response register
// lets the pipeline hold its contents whenever the response side stalls.
module box_mesh_rotate_bounds #(
   parameter int MAX_VERTICES = bmrb_pkg::DEF_MAX_VERTICES
) (
   input logic         clock,
   input logic         reset,
   bmrb_req_if.sink    req_chan,
   bmrb_rsp_if.source  rsp_chan
);

   bmrb_pkg::item_type head;
   logic               head_valid;
   logic               head_pop;

   bmrb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   bmrb_back #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
